// ===== rtl/core/rcbp_pkg.sv =====
// Shared constants and types for the range coded bit packer.
package rcbp_pkg;

  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned WORK_W      = VALUE_WIDTH + BYTE_W;
  localparam int unsigned NB_W        = $clog2(VALUE_WIDTH + 1);
  localparam int unsigned TOT_W       = $clog2(WORK_W + 1);
  localparam int unsigned POS_W       = $clog2(BYTE_W);
  localparam int unsigned QDEPTH      = 2;
  localparam int unsigned QPTR_W      = $clog2(QDEPTH);
  localparam int unsigned QCNT_W      = $clog2(QDEPTH + 1);

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef struct packed {
    logic                   flush;
    logic [VALUE_WIDTH-1:0] bits;
    logic [NB_W-1:0]        nbits;
  } rcbp_entry_t;

endpackage

// ===== rtl/core/rcbp_front.sv =====
// Front stage: turns an input item into a queue entry with masked bits and a bit count.
module rcbp_front (
  input  logic                            cmd_i,
  input  logic [rcbp_pkg::VALUE_WIDTH-1:0] value_i,
  input  logic [rcbp_pkg::VALUE_WIDTH-1:0] low_bound_i,
  input  logic [rcbp_pkg::VALUE_WIDTH-1:0] high_bound_i,
  input  logic                            signed_mode_i,
  output rcbp_pkg::rcbp_entry_t           entry_o
);
  import rcbp_pkg::*;

  logic [VALUE_WIDTH-1:0] bias;
  logic [VALUE_WIDTH-1:0] v_b;
  logic [VALUE_WIDTH-1:0] lo_b;
  logic [VALUE_WIDTH-1:0] hi_b;
  logic [VALUE_WIDTH-1:0] diff;
  logic [VALUE_WIDTH-1:0] span;
  logic [NB_W-1:0]        nbits;
  logic [VALUE_WIDTH:0]   mask;

  always_comb begin
    bias = signed_mode_i ? {1'b1, {(VALUE_WIDTH-1){1'b0}}} : '0;
    v_b  = value_i + bias;
    lo_b = low_bound_i + bias;
    hi_b = high_bound_i + bias;
    diff = v_b - lo_b;
    span = hi_b - lo_b;
    nbits = '0;
    for (int i = 0; i < VALUE_WIDTH; i++) begin
      if (span[i]) begin
        nbits = NB_W'(i + 1);
      end
    end
    mask = ((VALUE_WIDTH+1)'(1) << nbits) - (VALUE_WIDTH+1)'(1);
    entry_o.flush = (cmd_i == CMD_FLUSH);
    entry_o.bits  = diff & mask[VALUE_WIDTH-1:0];
    entry_o.nbits = (cmd_i == CMD_FLUSH) ? '0 : nbits;
  end

endmodule

// ===== rtl/core/rcbp_queue.sv =====
// Two-entry queue that decouples the front stage from the packing back end.
module rcbp_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  rcbp_pkg::rcbp_entry_t push_data_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  valid_o,
  output rcbp_pkg::rcbp_entry_t pop_data_o
);
  import rcbp_pkg::*;

  rcbp_entry_t       mem_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d;
  logic [QPTR_W-1:0] rptr_q, rptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == QCNT_W'(QDEPTH));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = push_i ? wptr_q + QPTR_W'(1) : wptr_q;
    rptr_d = pop_i ? rptr_q + QPTR_W'(1) : rptr_q;
    cnt_d  = cnt_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/core/rcbp_back.sv =====
// Back end: merges entry bits into the partial byte and emits completed bytes.
module rcbp_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  rcbp_pkg::rcbp_entry_t q_data_i,
  output logic                  q_pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            out_byte_o,
  output logic                  last_o
);
  import rcbp_pkg::*;

  logic [BYTE_W-1:0] partial_q, partial_d;
  logic [POS_W-1:0]  bitpos_q, bitpos_d;
  logic [WORK_W-1:0] work_q, work_d;
  logic [TOT_W-1:0]  tot_q, tot_d;
  logic              busy_q, busy_d;
  logic              ovalid_q, ovalid_d;
  logic [BYTE_W-1:0] obyte_q, obyte_d;
  logic              olast_q, olast_d;
  logic              slot_free;
  logic [TOT_W-1:0]  tot_sum;
  logic [TOT_W-1:0]  sh;
  logic [WORK_W-1:0] merged;

  assign out_valid_o = ovalid_q;
  assign out_byte_o  = obyte_q;
  assign last_o      = olast_q;

  always_comb begin
    slot_free = !ovalid_q || out_ready_i;
    tot_sum   = TOT_W'(bitpos_q) + TOT_W'(q_data_i.nbits);
    sh        = TOT_W'(WORK_W) - tot_sum;
    merged    = {partial_q, {VALUE_WIDTH{1'b0}}} | (WORK_W'(q_data_i.bits) << sh);

    partial_d = partial_q;
    bitpos_d  = bitpos_q;
    work_d    = work_q;
    tot_d     = tot_q;
    busy_d    = busy_q;
    ovalid_d  = ovalid_q && !out_ready_i;
    obyte_d   = obyte_q;
    olast_d   = olast_q;
    q_pop_o   = 1'b0;

    if (busy_q) begin
      if (slot_free) begin
        ovalid_d = 1'b1;
        obyte_d  = work_q[WORK_W-1 -: BYTE_W];
        olast_d  = (tot_q < TOT_W'(2 * BYTE_W));
        if (tot_q < TOT_W'(2 * BYTE_W)) begin
          partial_d = work_q[WORK_W-BYTE_W-1 -: BYTE_W];
          bitpos_d  = tot_q[POS_W-1:0];
          busy_d    = 1'b0;
        end else begin
          work_d = work_q << BYTE_W;
          tot_d  = tot_q - TOT_W'(BYTE_W);
        end
      end
    end else if (q_valid_i) begin
      if (q_data_i.flush) begin
        if (bitpos_q == '0) begin
          q_pop_o   = 1'b1;
          partial_d = '0;
        end else if (slot_free) begin
          q_pop_o   = 1'b1;
          ovalid_d  = 1'b1;
          obyte_d   = partial_q;
          olast_d   = 1'b1;
          partial_d = '0;
          bitpos_d  = '0;
        end
      end else begin
        q_pop_o = 1'b1;
        if (tot_sum < TOT_W'(BYTE_W)) begin
          partial_d = merged[WORK_W-1 -: BYTE_W];
          bitpos_d  = tot_sum[POS_W-1:0];
        end else begin
          busy_d = 1'b1;
          work_d = merged;
          tot_d  = tot_sum;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      bitpos_q  <= '0;
      busy_q    <= 1'b0;
      ovalid_q  <= 1'b0;
    end else begin
      partial_q <= partial_d;
      bitpos_q  <= bitpos_d;
      busy_q    <= busy_d;
      ovalid_q  <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q  <= work_d;
    tot_q   <= tot_d;
    obyte_q <= obyte_d;
    olast_q <= olast_d;
  end

endmodule

// ===== rtl/core/range_coded_bit_packer_top.sv =====
// Top level of the range coded bit packer: front stage, queue and back end.
// A completed byte goes from the queue through the work register to the output register.
// A write that completes k bytes (k at most 4) holds the back end until they have all gone out
// one at a time through the single byte-wide output register; a stalled output holds it longer.
// A two-entry queue lets items be accepted while earlier bytes are still being emitted.
// Reset clears the queue, the partial byte, the bit position and the output valid.
module range_coded_bit_packer_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             cmd_i,
  input  logic [rcbp_pkg::VALUE_WIDTH-1:0] value_i,
  input  logic [rcbp_pkg::VALUE_WIDTH-1:0] low_bound_i,
  input  logic [rcbp_pkg::VALUE_WIDTH-1:0] high_bound_i,
  input  logic                             signed_mode_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [7:0]                       out_byte_o,
  output logic                             last_o
);
  import rcbp_pkg::*;

  rcbp_entry_t entry;
  rcbp_entry_t q_data;
  logic        q_full;
  logic        q_valid;
  logic        q_pop;
  logic        push;

  assign in_ready_o = !q_full;
  assign push       = in_valid_i && !q_full;

  rcbp_front u_front (
    .cmd_i        (cmd_i),
    .value_i      (value_i),
    .low_bound_i  (low_bound_i),
    .high_bound_i (high_bound_i),
    .signed_mode_i(signed_mode_i),
    .entry_o      (entry)
  );

  rcbp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(entry),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_data_o (q_data)
  );

  rcbp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_data_i   (q_data),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_byte_o (out_byte_o),
    .last_o     (last_o)
  );

endmodule

// ===== rtl/core/rcbp_checker.sv =====
// Port-level checks for the range coded bit packer and their binding to the top level.
module rcbp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic       last_o
);

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o && in_ready_o)
    else $error("outputs not idle during reset");

  a_ready_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o && !in_valid_i |=> in_ready_o)
    else $error("input ready dropped without an accepted item");

  a_out_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o) && $stable(last_o))
    else $error("stalled output item changed or vanished");

endmodule

bind range_coded_bit_packer_top rcbp_checker u_rcbp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_byte_o (out_byte_o),
  .last_o     (last_o)
);
